/* hw/rtl/button_press_classifier_assert.svh */
// Assertion macros for the button press classifier RTL.
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bpc_pkg.sv */
// Shared types, constants and a helper function for the button press classifier.
package bpc_pkg;

    // Default tick counter width
    localparam int TICK_BITS_DEFAULT = 32;

    // Configuration port geometry
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int THRESH_W   = 16;
    localparam logic [THRESH_W-1:0] LONG_PRESS_RESET = 16'd500;

    // Register index decoded from paddr[2]
    typedef enum logic [0:0] {
        REG_LONG_PRESS = 1'b0,
        REG_UNMAPPED   = 1'b1
    } t_reg_idx;

    // Button set bits
    localparam logic [2:0] BTN_NONE   = 3'b000;
    localparam logic [2:0] BTN_MIDDLE = 3'b001;
    localparam logic [2:0] BTN_RIGHT  = 3'b010;
    localparam logic [2:0] BTN_LEFT   = 3'b100;

    // Event codes
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_MIDDLE_SHORT = 3'd1;
    localparam logic [2:0] EV_RIGHT_SHORT  = 3'd2;
    localparam logic [2:0] EV_LEFT_SHORT   = 3'd3;
    localparam logic [2:0] EV_MIDDLE_LONG  = 3'd4;
    localparam logic [2:0] EV_RIGHT_LONG   = 3'd5;
    localparam logic [2:0] EV_LEFT_LONG    = 3'd6;

    // Configuration seen by the classifier
    typedef struct packed {
        logic [THRESH_W-1:0] long_press_ticks;
    } t_cfg;

    // Map a single-button set to its short or long event; an empty set or a combination gives none
    function automatic logic [2:0] single_code(input logic [2:0] set, input logic is_long);
        logic [2:0] code;
        code = EV_NONE;
        case (set)
            BTN_MIDDLE: code = is_long ? EV_MIDDLE_LONG : EV_MIDDLE_SHORT;
            BTN_RIGHT:  code = is_long ? EV_RIGHT_LONG  : EV_RIGHT_SHORT;
            BTN_LEFT:   code = is_long ? EV_LEFT_LONG   : EV_LEFT_SHORT;
            default:    code = EV_NONE;
        endcase
        return code;
    endfunction

endpackage

/* hw/rtl/bpc_regs.sv */
// APB-style configuration register file for the button press classifier.
module bpc_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bpc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bpc_pkg::APB_DATA_W-1:0]   prdata,
    output bpc_pkg::t_cfg                    o_cfg
);

    logic [bpc_pkg::THRESH_W-1:0] r_long_press_ticks;
    bpc_pkg::t_reg_idx            w_idx;
    logic                         w_wr;

    // Decode the word index and the write strobe of the access phase
    assign w_idx = bpc_pkg::t_reg_idx'(paddr[2]);
    assign w_wr  = psel & penable & pwrite;

    // Update the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ticks <= bpc_pkg::LONG_PRESS_RESET;
        end else if (w_wr && (w_idx == bpc_pkg::REG_LONG_PRESS)) begin
            r_long_press_ticks <= pwdata[bpc_pkg::THRESH_W-1:0];
        end
    end

    // Return register contents on reads
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            bpc_pkg::REG_LONG_PRESS: prdata = bpc_pkg::APB_DATA_W'(r_long_press_ticks);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg.long_press_ticks = r_long_press_ticks;

endmodule

/* hw/rtl/button_press_classifier.sv */
// Top level of the button press classifier: input register, classify step, result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one poll request: the three
//   button levels (1 = pressed) and the free-running tick count. Output channel
//   (o_out_valid / i_out_ready) returns exactly one event code per poll:
//   0 none, 1..3 middle/right/left short, 4..6 middle/right/left long.
//   The APB-style port holds long_press_ticks at byte address 0 (reset 500);
//   write it only while no request is in flight.
// Path: an accepted request waits in the input register, is classified there, and
//   its event is loaded into the result register when the request advances.
// Throughput: 1 request per cycle unless the event channel stalls; the rate is set by the single
//   classify step (one tick subtraction and threshold compare) between the two registers.
// Reset: clears both stage valids, the press latch, the long flag and the
//   change tick, and loads the threshold with 500.
// Stall: while i_out_ready is low the result register holds its event; one more
//   request is taken into the input register, then o_in_ready drops.
module button_press_classifier #(
    parameter int TICK_BITS = bpc_pkg::TICK_BITS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Poll request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_left_pressed,
    input  logic                             i_right_pressed,
    input  logic                             i_middle_pressed,
    input  logic [31:0]                      i_now_tick,
    // Event channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [2:0]                       o_event_code,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bpc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bpc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    `include "button_press_classifier_assert.svh"

    localparam int CMP_W = (TICK_BITS > bpc_pkg::THRESH_W) ? TICK_BITS : bpc_pkg::THRESH_W;

    bpc_pkg::t_cfg          w_cfg;

    // Input register
    logic                   r_in_vld;
    logic [2:0]             r_in_set;
    logic [31:0]            r_in_tick;

    // Press state
    logic [2:0]             r_latch;
    logic                   r_long_seen;
    logic [TICK_BITS-1:0]   r_change_tick;
    logic [2:0]             n_latch;
    logic                   n_long_seen;
    logic [TICK_BITS-1:0]   n_change_tick;

    // Result register
    logic                   r_out_vld;
    logic [2:0]             r_out_code;

    logic                   w_adv;
    logic [TICK_BITS-1:0]   w_now;
    logic [TICK_BITS-1:0]   w_diff;
    logic                   w_long_ok;
    logic [2:0]             w_code;

    bpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    assign pready = 1'b1;

    // Advance the held request when the result register is free or being drained
    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    // Capture a poll request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_set  <= {i_left_pressed, i_right_pressed, i_middle_pressed};
            r_in_tick <= i_now_tick;
        end
    end

    // Wrap the tick into the counter width and test the hold time
    assign w_now     = TICK_BITS'(r_in_tick);
    assign w_diff    = w_now - r_change_tick;
    assign w_long_ok = CMP_W'(w_diff) >= CMP_W'(w_cfg.long_press_ticks);

    // Classify the held request against the press latch
    always_comb begin
        n_latch       = r_latch;
        n_long_seen   = r_long_seen;
        n_change_tick = r_change_tick;
        w_code        = bpc_pkg::EV_NONE;
        if (r_in_set == r_latch) begin
            if ((r_in_set != bpc_pkg::BTN_NONE) && w_long_ok) begin
                n_long_seen = 1'b1;
                w_code      = bpc_pkg::single_code(r_in_set, 1'b1);
            end
        end else begin
            if (r_in_set != bpc_pkg::BTN_NONE) begin
                n_latch = r_latch | r_in_set;
            end else begin
                if (!r_long_seen) begin
                    w_code = bpc_pkg::single_code(r_latch, 1'b0);
                end
                n_latch     = bpc_pkg::BTN_NONE;
                n_long_seen = 1'b0;
            end
            n_change_tick = w_now;
        end
    end

    // Commit press state when the request advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch       <= bpc_pkg::BTN_NONE;
            r_long_seen   <= 1'b0;
            r_change_tick <= '0;
        end else if (w_adv) begin
            r_latch       <= n_latch;
            r_long_seen   <= n_long_seen;
            r_change_tick <= n_change_tick;
        end
    end

    // Load or drain the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_code <= w_code;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_event_code = r_out_code;

    // Checks
    `BPC_ASSERT_IMPL(a_code_range, o_out_valid, o_event_code <= bpc_pkg::EV_LEFT_LONG, "event code out of range")
    `BPC_ASSERT_IMPL(a_flag_needs_latch, r_latch == bpc_pkg::BTN_NONE, !r_long_seen, "long flag set with empty latch")
    `BPC_ASSERT_NEXT(a_long_sets_flag, w_adv && (w_code >= bpc_pkg::EV_MIDDLE_LONG), r_long_seen, "long press without flag")
    `BPC_ASSERT_NEXT(a_short_clears, w_adv && (w_code != bpc_pkg::EV_NONE) && (w_code <= bpc_pkg::EV_LEFT_SHORT), r_latch == bpc_pkg::BTN_NONE, "short press left latch set")

endmodule
